// File: rtl/oms_pkg.sv
// ----------------------------------------------------------------------------
// oms_pkg: shared types and constants for the off-time mode selector
// Level table, hidden mode codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package oms_pkg;

    // Table geometry and how much of it is in use
    localparam int ROM_ROWS     = 8;
    localparam int ROM_COLS     = 8;
    localparam int HID_MAX      = 4;
    localparam int GROUP_COUNT  = 8;
    localparam int GROUP_WIDTH  = 8;
    localparam int HIDDEN_COUNT = 4;

    localparam int ROW_USED = (GROUP_WIDTH < ROM_COLS) ? GROUP_WIDTH : ROM_COLS;
    localparam int HID_USED = (HIDDEN_COUNT < HID_MAX) ? HIDDEN_COUNT : HID_MAX;

    // Special level codes
    localparam logic [7:0] MOON_LEVEL   = 8'd1;
    localparam logic [7:0] CODE_STROBE  = 8'd250;
    localparam logic [7:0] CODE_BATT    = 8'd254;
    localparam logic [7:0] CODE_BEACON  = 8'd251;
    localparam logic [7:0] CODE_TOP     = 8'd8;

    // Fast press count limit before the config menu is entered
    localparam logic [4:0] FAST_LIMIT = 5'h0f;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE_GROUP    = 3'd0;
    localparam logic [2:0] REG_MOON_ENABLE   = 3'd1;
    localparam logic [2:0] REG_REVERSE_ORDER = 3'd2;
    localparam logic [2:0] REG_MODE_MEMORY   = 3'd3;
    localparam logic [2:0] REG_MEDIUM_ENABLE = 3'd4;
    localparam logic [2:0] REG_SHORT_THRESH  = 3'd5;
    localparam logic [2:0] REG_MEDIUM_THRESH = 3'd6;

    // Press classes
    localparam logic [1:0] PRESS_SHORT   = 2'd0;
    localparam logic [1:0] PRESS_MEDIUM  = 2'd1;
    localparam logic [1:0] PRESS_LONG    = 2'd2;
    localparam logic [1:0] PRESS_SETTLED = 2'd3;

    // Request types
    localparam logic REQ_POWER_UP = 1'b0;
    localparam logic REQ_SETTLED  = 1'b1;

    // Level table, one row per mode group, zero ends a row
    localparam logic [7:0] LEVEL_ROM [0:ROM_ROWS-1][0:ROM_COLS-1] = '{
        '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8},
        '{8'd1, 8'd2, 8'd4, 8'd5, 8'd6, 8'd8, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd0},
        '{8'd1, 8'd4, 8'd5, 8'd6, 8'd8, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd2, 8'd4, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd5, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd0, 8'd0},
        '{8'd3, 8'd4, 8'd6, 8'd8, 8'd1, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [7:0] HIDDEN_CODES [0:HID_MAX-1] = '{
        CODE_STROBE, CODE_BATT, CODE_BEACON, CODE_TOP
    };

    // One result record
    typedef struct packed {
        logic [3:0] mode_index;
        logic [7:0] level_code;
        logic       is_hidden;
        logic [1:0] press_class;
        logic       enter_config;
    } result_t;

endpackage

// File: rtl/offtime_mode_selector_top.sv
// ----------------------------------------------------------------------------
// offtime_mode_selector_top: off-time press classifier and mode stepper
// Classes each power-up by its off-time reading, steps the mode index through
// the list built from the selected group, and reports the picked level.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------
//  in       | input     | in_valid / in_stall | req_type, offtime_reading
//  out      | output    | out_valid/out_stall | mode_index, level_code,
//           |           |                     | is_hidden, press_class,
//           |           |                     | enter_config
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One transaction per cycle while in_stall is low; each result is registered.
//  The list build and index step are one combinational pass into the result
//  register; state is updated at the same edge.
//  A two-entry output (result register plus skid register) lets input flow on
//  while one result is stalled; in_stall rises only once both are full.
//  rst_n clears the state and the valid flags and sets the config registers to their defaults.
// ----------------------------------------------------------------------------
module offtime_mode_selector_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] offtime_reading,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] mode_index,
    output logic [7:0] level_code,
    output logic       is_hidden,
    output logic [1:0] press_class,
    output logic       enter_config,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers
    logic [2:0] mode_group_reg;
    logic       moon_enable_reg;
    logic       reverse_order_reg;
    logic       mode_memory_reg;
    logic       medium_enable_reg;
    logic [7:0] short_thresh_reg;
    logic [7:0] medium_thresh_reg;

    // Selector state
    logic [3:0] current_index_reg, current_index_next;
    logic [4:0] fast_count_reg, fast_count_next;

    // Output side
    oms_pkg::result_t out_reg, skid_reg, result_next;
    logic             out_valid_reg, skid_valid_reg;

    logic       in_accept;
    logic       out_take;
    logic       row_ok;
    logic [3:0] nreg;
    logic [3:0] nhid;
    logic [3:0] list_reg;
    logic [3:0] list_len;
    logic [3:0] fwd_index;
    logic [3:0] back_index;
    logic [3:0] step_index;
    logic [4:0] count_step;
    logic [1:0] cls;
    logic       cfg_hit;
    logic [3:0] col;
    logic [3:0] hid_pos;
    logic [7:0] level;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid & ~skid_valid_reg;
    assign out_take  = out_valid_reg & ~out_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_group_reg    <= '0;
            moon_enable_reg   <= 1'b0;
            reverse_order_reg <= 1'b0;
            mode_memory_reg   <= 1'b0;
            medium_enable_reg <= 1'b1;
            short_thresh_reg  <= 8'd190;
            medium_thresh_reg <= 8'd94;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                oms_pkg::REG_MODE_GROUP:    mode_group_reg    <= cfg_data[2:0];
                oms_pkg::REG_MOON_ENABLE:   moon_enable_reg   <= cfg_data[0];
                oms_pkg::REG_REVERSE_ORDER: reverse_order_reg <= cfg_data[0];
                oms_pkg::REG_MODE_MEMORY:   mode_memory_reg   <= cfg_data[0];
                oms_pkg::REG_MEDIUM_ENABLE: medium_enable_reg <= cfg_data[0];
                oms_pkg::REG_SHORT_THRESH:  short_thresh_reg  <= cfg_data;
                oms_pkg::REG_MEDIUM_THRESH: medium_thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // List shape: regular count is the run of nonzero levels in the row
    always_comb
    begin
        row_ok = (int'(mode_group_reg) < oms_pkg::GROUP_COUNT)
              && (int'(mode_group_reg) < oms_pkg::ROM_ROWS);
        nreg = 4'(oms_pkg::ROW_USED);
        for (int i = oms_pkg::ROM_COLS - 1; i >= 0; i--)
        begin
            if (i < oms_pkg::ROW_USED
                && oms_pkg::LEVEL_ROM[mode_group_reg][i] == 8'd0)
            begin
                nreg = 4'(i);
            end
        end
        if (!row_ok)
        begin
            nreg = 4'd0;
        end
        nhid = 4'(oms_pkg::HID_USED);
        if (reverse_order_reg && nhid != 4'd0)
        begin
            nhid = nhid - 4'd1;
        end
        list_reg = nreg + {3'b000, moon_enable_reg};
        list_len = list_reg + nhid;
    end

    // Press class, index step and fast press count
    always_comb
    begin
        fwd_index = current_index_reg + 4'd1;
        if (fwd_index >= list_reg)
        begin
            fwd_index = 4'd0;
        end

        if (current_index_reg == list_reg)
            back_index = 4'd0;
        else if (current_index_reg != 4'd0)
            back_index = current_index_reg - 4'd1;
        else if (list_len == 4'd0)
            back_index = 4'd0;
        else
            back_index = list_len - 4'd1;

        count_step = fast_count_reg + 5'd1;
        step_index = current_index_reg;
        fast_count_next = 5'd0;

        if (req_type == oms_pkg::REQ_SETTLED)
        begin
            cls = oms_pkg::PRESS_SETTLED;
        end
        else if (offtime_reading > short_thresh_reg)
        begin
            cls = oms_pkg::PRESS_SHORT;
            fast_count_next = count_step;
            step_index = fwd_index;
        end
        else if (offtime_reading > medium_thresh_reg)
        begin
            cls = oms_pkg::PRESS_MEDIUM;
            step_index = medium_enable_reg ? back_index : fwd_index;
        end
        else
        begin
            cls = oms_pkg::PRESS_LONG;
            if (!mode_memory_reg)
            begin
                step_index = 4'd0;
            end
        end

        // Too many fast presses: enter config, start over
        cfg_hit = fast_count_next > oms_pkg::FAST_LIMIT;
        current_index_next = step_index;
        if (cfg_hit)
        begin
            fast_count_next    = 5'd0;
            current_index_next = 4'd0;
        end
    end

    // Level lookup at the new index
    always_comb
    begin
        level   = 8'd0;
        hid_pos = current_index_next - list_reg;
        if (reverse_order_reg)
            col = nreg - 4'd1 - current_index_next;
        else
            col = current_index_next - {3'b000, moon_enable_reg};

        if (current_index_next < list_reg)
        begin
            if (reverse_order_reg && current_index_next == nreg)
                level = oms_pkg::MOON_LEVEL;
            else if (!reverse_order_reg && moon_enable_reg && current_index_next == 4'd0)
                level = oms_pkg::MOON_LEVEL;
            else
                level = oms_pkg::LEVEL_ROM[mode_group_reg][col[2:0]];
        end
        else if (current_index_next < list_len)
        begin
            level = oms_pkg::HIDDEN_CODES[hid_pos[1:0]];
        end

        result_next.mode_index   = current_index_next;
        result_next.level_code   = level;
        result_next.is_hidden    = current_index_next >= list_reg;
        result_next.press_class  = cls;
        result_next.enter_config = cfg_hit;
    end

    // Selector state update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_index_reg <= '0;
            fast_count_reg    <= '0;
        end
        else if (in_accept)
        begin
            current_index_reg <= current_index_next;
            fast_count_reg    <= fast_count_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= result_next;
            else
                skid_reg <= result_next;
        end
        else if (out_take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mode_index   = out_reg.mode_index;
    assign level_code   = out_reg.level_code;
    assign is_hidden    = out_reg.is_hidden;
    assign press_class  = out_reg.press_class;
    assign enter_config = out_reg.enter_config;

`ifndef NO_ASSERTIONS
    // Skid holds data only behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid without output register");

    // Fast press count is cleared once it passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fast_count_reg <= oms_pkg::FAST_LIMIT)
        else $error("fast press count above limit");

    // Config entry always lands on the first mode
    a_cfg_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.enter_config |-> out_reg.mode_index == 4'd0)
        else $error("config entry with nonzero mode index");

    // A settled event clears the press count
    a_settled_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && req_type == oms_pkg::REQ_SETTLED |=> fast_count_reg == 5'd0)
        else $error("settled event did not clear press count");

    // Only an index past the list reads as level zero
    a_zero_is_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.level_code == 8'd0 |-> out_reg.is_hidden)
        else $error("level zero reported for a regular mode");
`endif

endmodule
